### rtl/hmap_pkg.sv
// Package for the hash map unit: sizes, operation and status codes,
// the row layout of the slot memory and the slot match record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hmap_pkg;

	localparam int BUCKETS  = 10;
	localparam int WAYS     = 4;

	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 16;
	localparam int WORD_W   = 64;
	localparam int STATUS_W = 3;
	localparam int FILL_W   = 3;

	localparam int BKT_W    = $clog2(BUCKETS);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W    = $clog2(WAYS + 1);

	// key mod BUCKETS by reciprocal: the estimate is low by at most one,
	// so the remainder estimate stays below twice BUCKETS
	localparam int RECIP_SHIFT = KEY_W + 8;
	localparam int RECIP_MULT  = (1 << RECIP_SHIFT) / BUCKETS;
	localparam int PROD_W      = KEY_W + RECIP_SHIFT;
	localparam int REM_W       = $clog2(2 * BUCKETS);
	localparam int DIFF_W      = KEY_W + 8;

	typedef enum logic [FUNC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NEW   = 3'd0,
		ST_OVER  = 3'd1,
		ST_FOUND = 3'd2,
		ST_MISS  = 3'd3,
		ST_DEL   = 3'd4,
		ST_FULL  = 3'd5
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] word;
	} slot_t;

	typedef slot_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] hit_way;
		logic             free;
		logic [WAY_W-1:0] free_way;
	} match_t;

endpackage

`default_nettype wire

### rtl/hmap_if.sv
// Request and response channel interfaces of the hash map unit.
// Depends on hmap_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hmap_req_if import hmap_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [KEY_W-1:0]  key;
	logic [WORD_W-1:0] data_word;

	modport source (output valid, func, key, data_word, input ready);
	modport sink   (input valid, func, key, data_word, output ready);
endinterface

interface hmap_rsp_if import hmap_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   read_word;
	logic [FILL_W-1:0]   bucket_fill;

	modport source (output valid, status, read_word, bucket_fill, input ready);
	modport sink   (input valid, status, read_word, bucket_fill, output ready);
endinterface

`default_nettype wire

### rtl/hmap_row_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hmap_row_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/hmap_slot_match.sv
// Parallel key compare over one bucket row: first matching slot and
// lowest free slot. Depends on hmap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmap_slot_match import hmap_pkg::*; (
	input  wire row_t             row,
	input  wire logic [WAYS-1:0]  valid,
	input  wire logic [KEY_W-1:0] key,
	output match_t                match
);

	// walk downwards so the lowest-numbered slot wins
	always_comb begin
		match = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid[w]) begin
				if (row[w].key == key) begin
					match.hit     = 1'b1;
					match.hit_way = WAY_W'(w);
				end
			end else begin
				match.free     = 1'b1;
				match.free_way = WAY_W'(w);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/hash_map_insert_lookup_delete_unit.sv
// Top level of the hash map unit: hashing, row memory read-modify-write
// and result register. Depends on hmap_pkg, hmap_if, hmap_row_ram, hmap_slot_match.
`timescale 1ns / 1ps
`default_nettype none

// Key-value map of BUCKETS buckets with WAYS slots each. A request
// transaction carries func (insert/overwrite, lookup, delete), a 16-bit key
// and a 64-bit data word; each request yields exactly one response
// transaction with status, read_word and the bucket's fill after the
// operation. The bucket is key mod BUCKETS, and insert takes the lowest
// free slot. Keys and words of a bucket sit in one row of a synchronous
// RAM; slot valid bits are flip-flops cleared by reset, so the map is empty
// straight out of reset with no clearing pass. A request forms the bucket
// index in stage 1 while the row read is issued, and compares and writes
// back in stage 2; its response is then registered. Stage 1 can take a
// new request while stage 2 holds one, but the row read of a request is
// held until the write-back of the request ahead of it has landed in the
// RAM, which keeps the read-modify-write of a bucket free of stale data.
// A stalled response holds the compare stage, and the request side keeps
// taking one request meanwhile.
module hash_map_insert_lookup_delete_unit import hmap_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hmap_req_if.sink    req,
	hmap_rsp_if.source  rsp
);

	// stage 1: key, reciprocal quotient estimate
	logic              v_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [WORD_W-1:0] word_s1;
	logic [KEY_W-1:0]  quo_s1;

	// stage 2: row read data valid, compare and write back
	logic              v_s2;
	logic [FUNC_W-1:0] func_s2;
	logic [KEY_W-1:0]  key_s2;
	logic [WORD_W-1:0] word_s2;
	logic [BKT_W-1:0]  bucket_s2;

	// response register
	logic                rsp_v_q;
	status_t             status_q;
	logic [WORD_W-1:0]   read_q;
	logic [FILL_W-1:0]   fill_q;

	logic [WAYS-1:0] valid_q [BUCKETS];

	logic accept;
	logic adv_s1;
	logic adv_s2;

	logic [PROD_W-1:0] recip_prod;
	logic [DIFF_W-1:0] rem_full;
	logic [REM_W-1:0]  rem_est;
	logic [BKT_W-1:0]  bucket_s1;

	row_t            row_rd;
	row_t            row_wr;
	logic            row_we;
	logic [WAYS-1:0] valid_row;
	logic [WAYS-1:0] valid_nxt;
	match_t          match;
	status_t         status_nxt;
	logic [WORD_W-1:0] read_nxt;
	logic [CNT_W-1:0]  fill_nxt;

	// take a request while stage 1 is empty or moving on
	assign req.ready = !v_s1 || !v_s2;
	assign accept    = req.valid && req.ready;
	// interlock: read the row only once the write-back ahead has gone
	assign adv_s1    = v_s1 && !v_s2;
	assign adv_s2    = v_s2 && (!rsp_v_q || rsp.ready);

	assign recip_prod = PROD_W'(req.key) * PROD_W'(RECIP_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			key_s1  <= req.key;
			word_s1 <= req.data_word;
			quo_s1  <= recip_prod[RECIP_SHIFT +: KEY_W];
		end
	end

	// remainder from the estimate, then one correction step
	assign rem_full = DIFF_W'(key_s1) - DIFF_W'(quo_s1) * DIFF_W'(BUCKETS);
	assign rem_est  = rem_full[REM_W-1:0];

	always_comb begin
		if (rem_est >= REM_W'(BUCKETS)) begin
			bucket_s1 = BKT_W'(rem_est - REM_W'(BUCKETS));
		end else begin
			bucket_s1 = BKT_W'(rem_est);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= 1'b1;
		end else if (adv_s2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			func_s2   <= func_s1;
			key_s2    <= key_s1;
			word_s2   <= word_s1;
			bucket_s2 <= bucket_s1;
		end
	end

	// row data holds in the RAM output register while stage 2 waits
	hmap_row_ram #(
		.DEPTH (BUCKETS),
		.WIDTH (ROW_W)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (adv_s2 && row_we),
		.wr_addr (bucket_s2),
		.wr_data (row_wr),
		.rd_en   (adv_s1),
		.rd_addr (bucket_s1),
		.rd_data (row_rd)
	);

	assign valid_row = valid_q[bucket_s2];

	hmap_slot_match u_slot_match (
		.row   (row_rd),
		.valid (valid_row),
		.key   (key_s2),
		.match (match)
	);

	// decide the operation's outcome and the row to write back
	always_comb begin
		row_wr     = row_rd;
		row_we     = 1'b0;
		valid_nxt  = valid_row;
		status_nxt = ST_MISS;
		read_nxt   = '0;
		unique case (func_s2)
			OP_INSERT: begin
				if (match.hit) begin
					row_wr[match.hit_way].word = word_s2;
					row_we                     = 1'b1;
					status_nxt                 = ST_OVER;
				end else if (match.free) begin
					row_wr[match.free_way].key  = key_s2;
					row_wr[match.free_way].word = word_s2;
					row_we                      = 1'b1;
					valid_nxt[match.free_way]   = 1'b1;
					status_nxt                  = ST_NEW;
				end else begin
					status_nxt = ST_FULL;
				end
			end
			OP_LOOKUP: begin
				if (match.hit) begin
					read_nxt   = row_rd[match.hit_way].word;
					status_nxt = ST_FOUND;
				end
			end
			OP_DELETE: begin
				if (match.hit) begin
					valid_nxt[match.hit_way] = 1'b0;
					status_nxt               = ST_DEL;
				end
			end
			default: begin
				// unused code: change nothing, report a miss
				status_nxt = ST_MISS;
			end
		endcase
		fill_nxt = CNT_W'($countones(valid_nxt));
	end

	// bucket fill is the count of valid slots, so no separate counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
		end else if (adv_s2) begin
			valid_q[bucket_s2] <= valid_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (adv_s2) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			status_q <= status_nxt;
			read_q   <= read_nxt;
			fill_q   <= FILL_W'(fill_nxt);
		end
	end

	assign rsp.valid       = rsp_v_q;
	assign rsp.status      = status_q;
	assign rsp.read_word   = read_q;
	assign rsp.bucket_fill = fill_q;

endmodule

`default_nettype wire
